// ===== hw/rtl/dcs_pkg.sv =====
package dcs_pkg;

  // Number of spot positions searched in the spot angle register (1..8)
  localparam int unsigned Spots = 4;

  localparam int unsigned AngleMax  = 180;
  localparam int unsigned ParkReset = 170;

  // One-hot phase codes
  typedef enum logic [4:0] {
    PhIdle  = 5'b00001,
    PhMove  = 5'b00010,
    PhPump  = 5'b00100,
    PhDrain = 5'b01000,
    PhPark  = 5'b10000
  } phase_e;

  // Phase numbers as reported on the result channel
  typedef enum logic [2:0] {
    PnIdle  = 3'd0,
    PnMove  = 3'd1,
    PnPump  = 3'd2,
    PnDrain = 3'd3,
    PnPark  = 3'd4
  } phase_num_e;

  // Register index, taken from paddr[5:3]
  typedef enum logic [2:0] {
    RegParkAngle = 3'd0,
    RegFullSweep = 3'd1,
    RegPumpMs    = 3'd2,
    RegTotalWait = 3'd3,
    RegSpotAngle = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    LedNone   = 2'd0,
    LedYellow = 2'd1,
    LedGreen  = 2'd2
  } led_e;

  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrBadHead = 2'd1,
    ErrNoSpot  = 2'd2
  } err_e;

  function automatic logic [2:0] phase_num(phase_e ph);
    logic [2:0] n;
    unique case (ph)
      PhMove:  n = PnMove;
      PhPump:  n = PnPump;
      PhDrain: n = PnDrain;
      PhPark:  n = PnPark;
      default: n = PnIdle;
    endcase
    return n;
  endfunction

  // One-based spot for an angle, lowest match wins, 0 when none
  function automatic logic [3:0] spot_of(logic [63:0] angles, logic [7:0] a);
    logic [3:0] s;
    s = 4'd0;
    for (int k = Spots - 1; k >= 0; k--) begin
      if (angles[8*k +: 8] == a) s = 4'(k + 1);
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/dispense_cycle_sequencer.sv =====
// Dispense cycle sequencer.
// Input channel (in_valid_i / in_stall_o) carries one poll per transaction:
// a millisecond timestamp and the head of the outside job queue. Each poll
// yields exactly one result transaction (out_valid_o / out_stall_i) with the
// arm target, servo enable, pump and tower drive, LED event, pop request,
// error code and the phase after the poll.
// Timing: a poll is taken into an input register, the phase machine works
// on it combinationally and writes the result register. One poll per cycle
// is sustained while the result is not stalled; the phase state is updated
// combinationally, its move check using one 8x16 multiplier and a constant
// 180 shift-add.
// A stalled result holds the result register; the input register still
// takes one more poll, then in_stall_o rises until the result drains.
// Reset: idle phase, no job, arm at 170 degrees, all drives off, registers
// at their defaults. Configuration is written through the APB port at
// byte address 8*index; pready is always high.
module dispense_cycle_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  // poll channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        now_ms_i,
  input  logic               queue_nonempty_i,
  input  logic signed [8:0]  head_angle_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         servo_angle_o,
  output logic               servo_enable_o,
  output logic               pump_drive_o,
  output logic               tower_light_o,
  output logic [3:0]         spot_number_o,
  output logic [1:0]         led_event_o,
  output logic               pop_head_o,
  output logic [1:0]         error_flag_o,
  output logic [2:0]         phase_now_o
);

  // configuration registers
  logic [7:0]  park_angle_q;
  logic [15:0] full_sweep_q;
  logic [15:0] pump_ms_q;
  logic [15:0] total_wait_q;
  logic [63:0] spot_angles_q;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      park_angle_q  <= 8'(dcs_pkg::ParkReset);
      full_sweep_q  <= 16'd1000;
      pump_ms_q     <= 16'd3000;
      total_wait_q  <= 16'd5000;
      spot_angles_q <= 64'd0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        dcs_pkg::RegParkAngle: park_angle_q  <= pwdata[7:0];
        dcs_pkg::RegFullSweep: full_sweep_q  <= pwdata[15:0];
        dcs_pkg::RegPumpMs:    pump_ms_q     <= pwdata[15:0];
        dcs_pkg::RegTotalWait: total_wait_q  <= pwdata[15:0];
        dcs_pkg::RegSpotAngle: spot_angles_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      dcs_pkg::RegParkAngle: prdata = {56'd0, park_angle_q};
      dcs_pkg::RegFullSweep: prdata = {48'd0, full_sweep_q};
      dcs_pkg::RegPumpMs:    prdata = {48'd0, pump_ms_q};
      dcs_pkg::RegTotalWait: prdata = {48'd0, total_wait_q};
      dcs_pkg::RegSpotAngle: prdata = spot_angles_q;
      default:               prdata = 64'd0;
    endcase
  end

  // input register
  logic               in_valid_q;
  logic [31:0]        now_q;
  logic               nonempty_q;
  logic signed [8:0]  head_q;
  logic               fire;
  logic               in_take;

  assign fire       = in_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      now_q      <= now_ms_i;
      nonempty_q <= queue_nonempty_i;
      head_q     <= head_angle_i;
    end
  end

  // sequencer state
  dcs_pkg::phase_e    phase_q, phase_d;
  logic [31:0]        start_q, start_d;
  logic signed [8:0]  job_q, job_d;
  logic [7:0]         arm_q, arm_d;
  // |delta angle| * full_sweep_ms, the move time before the divide by 180
  logic [23:0]        move_prod_q, move_prod_d;
  logic               servo_q, servo_d;
  logic               pump_q, pump_d;

  logic [31:0] elapsed;
  logic        lost;
  logic        head_ok;
  logic [7:0]  park_sat;
  logic [7:0]  target;
  logic [7:0]  delta;
  logic [23:0] prod_new;
  logic        move_done;
  logic [15:0] e_m49;
  logic [23:0] e_x180;
  logic [3:0]  spot;

  logic [3:0]  spot_d;
  logic [1:0]  led_d;
  logic        pop_d;
  logic [1:0]  err_d;

  assign elapsed  = now_q - start_q;
  assign lost     = !nonempty_q || (head_q != job_q);
  assign head_ok  = !head_q[8] && (head_q[7:0] <= 8'(dcs_pkg::AngleMax));
  assign park_sat = (park_angle_q > 8'(dcs_pkg::AngleMax)) ? 8'(dcs_pkg::AngleMax)
                                                            : park_angle_q;
  assign target   = nonempty_q ? head_q[7:0] : park_sat;
  assign delta    = (arm_q > target) ? (arm_q - target) : (target - arm_q);
  assign prod_new = 24'(delta) * 24'(full_sweep_q);
  assign spot     = dcs_pkg::spot_of(spot_angles_q, job_q[7:0]);

  // elapsed >= min(prod/180 + 50, 65535), without a divider:
  // for elapsed in 50..65534 this is prod < (elapsed - 49) * 180
  assign e_m49     = elapsed[15:0] - 16'd49;
  assign e_x180    = {1'b0, e_m49, 7'd0} + {3'd0, e_m49, 5'd0}
                   + {4'd0, e_m49, 4'd0} + {6'd0, e_m49, 2'd0};
  assign move_done = (elapsed[31:16] != 16'd0) || (elapsed[15:0] == 16'hFFFF) ||
                     ((elapsed[15:0] >= 16'd50) && (move_prod_q < e_x180));

  always_comb begin
    phase_d     = phase_q;
    start_d     = start_q;
    job_d       = job_q;
    arm_d       = arm_q;
    move_prod_d = move_prod_q;
    servo_d     = servo_q;
    pump_d      = pump_q;
    spot_d      = 4'd0;
    led_d       = dcs_pkg::LedNone;
    pop_d       = 1'b0;
    err_d       = dcs_pkg::ErrNone;

    unique case (phase_q)
      dcs_pkg::PhMove: begin
        if (lost) begin
          job_d   = -9'sd1;
          phase_d = dcs_pkg::PhIdle;
        end else if (move_done) begin
          servo_d = 1'b0;
          if (spot != 4'd0) begin
            spot_d = spot;
            led_d  = dcs_pkg::LedYellow;
          end else begin
            err_d = dcs_pkg::ErrNoSpot;
          end
          pump_d  = 1'b1;
          start_d = now_q;
          phase_d = dcs_pkg::PhPump;
        end
      end
      dcs_pkg::PhPump: begin
        if (lost) begin
          pump_d  = 1'b0;
          job_d   = -9'sd1;
          phase_d = dcs_pkg::PhIdle;
        end else if (elapsed >= 32'(pump_ms_q)) begin
          pump_d = 1'b0;
          if (spot != 4'd0) begin
            spot_d = spot;
            led_d  = dcs_pkg::LedGreen;
          end else begin
            err_d = dcs_pkg::ErrNoSpot;
          end
          phase_d = dcs_pkg::PhDrain;
        end
      end
      dcs_pkg::PhDrain: begin
        if (lost) begin
          job_d   = -9'sd1;
          phase_d = dcs_pkg::PhIdle;
        end else if (elapsed >= 32'(total_wait_q)) begin
          pop_d   = 1'b1;
          job_d   = -9'sd1;
          phase_d = dcs_pkg::PhIdle;
        end
      end
      dcs_pkg::PhPark: begin
        if (move_done) begin
          servo_d = 1'b0;
          phase_d = dcs_pkg::PhIdle;
        end
      end
      default: begin
        // idle, and any stray code
        phase_d = dcs_pkg::PhIdle;
        if (nonempty_q) begin
          if (head_ok) begin
            job_d       = head_q;
            move_prod_d = prod_new;
            arm_d       = target;
            servo_d     = 1'b1;
            start_d     = now_q;
            phase_d     = dcs_pkg::PhMove;
          end else begin
            err_d = dcs_pkg::ErrBadHead;
          end
        end else begin
          if (arm_q != target) begin
            move_prod_d = prod_new;
            arm_d       = target;
            servo_d     = 1'b1;
            start_d     = now_q;
            phase_d     = dcs_pkg::PhPark;
          end
          pump_d = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= dcs_pkg::PhIdle;
      start_q     <= 32'd0;
      job_q       <= -9'sd1;
      arm_q       <= 8'(dcs_pkg::ParkReset);
      move_prod_q <= 24'd0;
      servo_q     <= 1'b0;
      pump_q      <= 1'b0;
    end else if (fire) begin
      phase_q     <= phase_d;
      start_q     <= start_d;
      job_q       <= job_d;
      arm_q       <= arm_d;
      move_prod_q <= move_prod_d;
      servo_q     <= servo_d;
      pump_q      <= pump_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (fire) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      servo_angle_o  <= arm_d;
      servo_enable_o <= servo_d;
      pump_drive_o   <= pump_d;
      tower_light_o  <= pump_d;
      spot_number_o  <= spot_d;
      led_event_o    <= led_d;
      pop_head_o     <= pop_d;
      error_flag_o   <= err_d;
      phase_now_o    <= dcs_pkg::phase_num(phase_d);
    end
  end

endmodule
